### rtl/rv64ex_pkg.sv
// rv64ex_pkg: operation codes, widths and the item structs of the rv64i execute unit
// no dependencies; imported by the channel interfaces, rv64ex_alu and rv64i_execute_unit
package rv64ex_pkg;

  localparam int XLEN      = 64;
  localparam int CMD_W     = 6;
  localparam int IMM_W     = 32;
  localparam int KIND_W    = 2;
  localparam int BYTES_W   = 4;
  localparam int SH_W      = 6;   // shift amount bits, 0x3f
  localparam int SHW_W     = 5;   // word shift amount bits, 0x1f
  localparam int WORD_W    = 32;

  localparam logic [XLEN-1:0] INSN_BYTES = XLEN'(4);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 6'd0,  CMD_SUB   = 6'd1,  CMD_AND   = 6'd2,  CMD_OR    = 6'd3,
    CMD_XOR   = 6'd4,  CMD_SLL   = 6'd5,  CMD_SRL   = 6'd6,  CMD_SRA   = 6'd7,
    CMD_SLT   = 6'd8,  CMD_SLTU  = 6'd9,  CMD_ADDW  = 6'd10, CMD_SUBW  = 6'd11,
    CMD_SLLW  = 6'd12, CMD_SRLW  = 6'd13, CMD_SRAW  = 6'd14, CMD_ADDI  = 6'd15,
    CMD_ANDI  = 6'd16, CMD_ORI   = 6'd17, CMD_XORI  = 6'd18, CMD_SLLI  = 6'd19,
    CMD_SRLI  = 6'd20, CMD_SRAI  = 6'd21, CMD_SLTI  = 6'd22, CMD_SLTIU = 6'd23,
    CMD_ADDIW = 6'd24, CMD_SLLIW = 6'd25, CMD_SRLIW = 6'd26, CMD_SRAIW = 6'd27,
    CMD_LB    = 6'd28, CMD_LBU   = 6'd29, CMD_LH    = 6'd30, CMD_LHU   = 6'd31,
    CMD_LW    = 6'd32, CMD_LWU   = 6'd33, CMD_LD    = 6'd34, CMD_SB    = 6'd35,
    CMD_SH    = 6'd36, CMD_SW    = 6'd37, CMD_SD    = 6'd38, CMD_BEQ   = 6'd39,
    CMD_BNE   = 6'd40, CMD_BGE   = 6'd41, CMD_BGEU  = 6'd42, CMD_BLT   = 6'd43,
    CMD_BLTU  = 6'd44, CMD_JAL   = 6'd45, CMD_JALR  = 6'd46, CMD_LUI   = 6'd47,
    CMD_AUIPC = 6'd48
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    MEM_NONE  = 2'd0,
    MEM_LOAD  = 2'd1,
    MEM_STORE = 2'd2
  } mem_kind_t;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [XLEN-1:0]         first_operand;
    logic [XLEN-1:0]         second_operand;
    logic signed [IMM_W-1:0] immediate;
    logic [XLEN-1:0]         current_pc;
    logic [XLEN-1:0]         loaded_raw;
  } insn_t;

  typedef struct packed {
    logic [XLEN-1:0]    dest_value;
    logic               dest_write;
    logic [XLEN-1:0]    next_pc;
    logic               branch_taken;
    logic [XLEN-1:0]    mem_address;
    logic [KIND_W-1:0]  mem_kind;
    logic [BYTES_W-1:0] mem_bytes;
    logic [XLEN-1:0]    store_value;
  } result_t;

endpackage

### rtl/rv64ex_channels.sv
// rv64ex channel interfaces: valid/ready channels for decoded instructions and results
// depends on rv64ex_pkg for widths
interface rv64ex_in_if;
  import rv64ex_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [XLEN-1:0]         first_operand;
  logic [XLEN-1:0]         second_operand;
  logic signed [IMM_W-1:0] immediate;
  logic [XLEN-1:0]         current_pc;
  logic [XLEN-1:0]         loaded_raw;

  modport source (
    output valid, cmd, first_operand, second_operand, immediate, current_pc, loaded_raw,
    input  ready
  );
  modport sink (
    input  valid, cmd, first_operand, second_operand, immediate, current_pc, loaded_raw,
    output ready
  );
endinterface

interface rv64ex_out_if;
  import rv64ex_pkg::*;

  logic               valid;
  logic               ready;
  logic [XLEN-1:0]    dest_value;
  logic               dest_write;
  logic [XLEN-1:0]    next_pc;
  logic               branch_taken;
  logic [XLEN-1:0]    mem_address;
  logic [KIND_W-1:0]  mem_kind;
  logic [BYTES_W-1:0] mem_bytes;
  logic [XLEN-1:0]    store_value;

  modport source (
    output valid, dest_value, dest_write, next_pc, branch_taken, mem_address, mem_kind,
           mem_bytes, store_value,
    input  ready
  );
  modport sink (
    input  valid, dest_value, dest_write, next_pc, branch_taken, mem_address, mem_kind,
           mem_bytes, store_value,
    output ready
  );
endinterface

### rtl/rv64ex_alu.sv
// rv64ex_alu: combinational evaluation of one decoded rv64i instruction
// depends on rv64ex_pkg (cmd_t, insn_t, result_t)
module rv64ex_alu (
  input  rv64ex_pkg::insn_t   insn,
  output rv64ex_pkg::result_t res
);
  import rv64ex_pkg::*;

  logic [XLEN-1:0]   a;
  logic [XLEN-1:0]   b;
  logic [XLEN-1:0]   imm64;
  logic [XLEN-1:0]   pc;
  logic [XLEN-1:0]   raw;
  logic              imm_form;
  logic [XLEN-1:0]   opb;
  logic [SH_W-1:0]   sh;
  logic [SHW_W-1:0]  shw;
  logic [XLEN-1:0]   sum;
  logic [XLEN-1:0]   diff;
  logic [XLEN-1:0]   addr;
  logic [XLEN-1:0]   pc_seq;
  logic [XLEN-1:0]   pc_rel;
  logic [WORD_W-1:0] lo;
  logic [WORD_W-1:0] sllw_res;
  logic [WORD_W-1:0] srlw_res;
  logic [WORD_W-1:0] sraw_res;
  logic              lt_s;
  logic              lt_u;
  logic              eq;

  assign a     = insn.first_operand;
  assign b     = insn.second_operand;
  assign imm64 = XLEN'($signed(insn.immediate));
  assign pc    = insn.current_pc;
  assign raw   = insn.loaded_raw;
  assign lo    = a[WORD_W-1:0];

  // immediate forms of the arithmetic group
  assign imm_form = (insn.cmd >= CMD_ADDI) && (insn.cmd <= CMD_SRAIW);
  assign opb      = imm_form ? imm64 : b;
  assign sh       = opb[SH_W-1:0];
  assign shw      = opb[SHW_W-1:0];

  assign sum    = a + opb;
  assign diff   = a - b;
  assign addr   = a + imm64;
  assign pc_seq = pc + INSN_BYTES;
  assign pc_rel = pc + imm64;

  assign sllw_res = lo << shw;
  assign srlw_res = lo >> shw;
  assign sraw_res = WORD_W'($signed(lo) >>> shw);

  assign lt_s = $signed(a) < $signed(opb);
  assign lt_u = a < opb;
  assign eq   = a == b;

  always_comb begin
    res              = '0;
    res.next_pc      = pc_seq;
    case (cmd_t'(insn.cmd))
      CMD_ADD, CMD_ADDI: begin
        res.dest_write = 1'b1;
        res.dest_value = sum;
      end
      CMD_SUB: begin
        res.dest_write = 1'b1;
        res.dest_value = diff;
      end
      CMD_AND, CMD_ANDI: begin
        res.dest_write = 1'b1;
        res.dest_value = a & opb;
      end
      CMD_OR, CMD_ORI: begin
        res.dest_write = 1'b1;
        res.dest_value = a | opb;
      end
      CMD_XOR, CMD_XORI: begin
        res.dest_write = 1'b1;
        res.dest_value = a ^ opb;
      end
      CMD_SLL, CMD_SLLI: begin
        res.dest_write = 1'b1;
        res.dest_value = a << sh;
      end
      CMD_SRL, CMD_SRLI: begin
        res.dest_write = 1'b1;
        res.dest_value = a >> sh;
      end
      CMD_SRA, CMD_SRAI: begin
        res.dest_write = 1'b1;
        res.dest_value = XLEN'($signed(a) >>> sh);
      end
      CMD_SLT, CMD_SLTI: begin
        res.dest_write = 1'b1;
        res.dest_value = XLEN'(lt_s);
      end
      CMD_SLTU, CMD_SLTIU: begin
        res.dest_write = 1'b1;
        res.dest_value = XLEN'(lt_u);
      end
      CMD_ADDW, CMD_ADDIW: begin
        res.dest_write = 1'b1;
        res.dest_value = XLEN'($signed(sum[WORD_W-1:0]));
      end
      CMD_SUBW: begin
        res.dest_write = 1'b1;
        res.dest_value = XLEN'($signed(diff[WORD_W-1:0]));
      end
      CMD_SLLW, CMD_SLLIW: begin
        res.dest_write = 1'b1;
        res.dest_value = XLEN'($signed(sllw_res));
      end
      CMD_SRLW, CMD_SRLIW: begin
        res.dest_write = 1'b1;
        res.dest_value = XLEN'($signed(srlw_res));
      end
      CMD_SRAW, CMD_SRAIW: begin
        res.dest_write = 1'b1;
        res.dest_value = XLEN'($signed(sraw_res));
      end
      CMD_LB, CMD_LBU, CMD_LH, CMD_LHU, CMD_LW, CMD_LWU, CMD_LD: begin
        res.dest_write  = 1'b1;
        res.mem_kind    = MEM_LOAD;
        res.mem_address = addr;
        case (cmd_t'(insn.cmd))
          CMD_LB: begin
            res.mem_bytes  = BYTES_W'(1);
            res.dest_value = XLEN'($signed(raw[7:0]));
          end
          CMD_LBU: begin
            res.mem_bytes  = BYTES_W'(1);
            res.dest_value = XLEN'(raw[7:0]);
          end
          CMD_LH: begin
            res.mem_bytes  = BYTES_W'(2);
            res.dest_value = XLEN'($signed(raw[15:0]));
          end
          CMD_LHU: begin
            res.mem_bytes  = BYTES_W'(2);
            res.dest_value = XLEN'(raw[15:0]);
          end
          CMD_LW: begin
            res.mem_bytes  = BYTES_W'(4);
            res.dest_value = XLEN'($signed(raw[WORD_W-1:0]));
          end
          CMD_LWU: begin
            res.mem_bytes  = BYTES_W'(4);
            res.dest_value = XLEN'(raw[WORD_W-1:0]);
          end
          default: begin
            res.mem_bytes  = BYTES_W'(8);
            res.dest_value = raw;
          end
        endcase
      end
      CMD_SB: begin
        res.mem_kind    = MEM_STORE;
        res.mem_address = addr;
        res.mem_bytes   = BYTES_W'(1);
        res.store_value = XLEN'(b[7:0]);
      end
      CMD_SH: begin
        res.mem_kind    = MEM_STORE;
        res.mem_address = addr;
        res.mem_bytes   = BYTES_W'(2);
        res.store_value = XLEN'(b[15:0]);
      end
      CMD_SW: begin
        res.mem_kind    = MEM_STORE;
        res.mem_address = addr;
        res.mem_bytes   = BYTES_W'(4);
        res.store_value = XLEN'(b[WORD_W-1:0]);
      end
      CMD_SD: begin
        res.mem_kind    = MEM_STORE;
        res.mem_address = addr;
        res.mem_bytes   = BYTES_W'(8);
        res.store_value = b;
      end
      CMD_BEQ, CMD_BNE, CMD_BGE, CMD_BGEU, CMD_BLT, CMD_BLTU: begin
        case (cmd_t'(insn.cmd))
          CMD_BEQ:  res.branch_taken = eq;
          CMD_BNE:  res.branch_taken = !eq;
          CMD_BGE:  res.branch_taken = !lt_s;
          CMD_BGEU: res.branch_taken = !lt_u;
          CMD_BLT:  res.branch_taken = lt_s;
          default:  res.branch_taken = lt_u;
        endcase
        if (res.branch_taken) begin
          res.next_pc = pc_rel;
        end
      end
      CMD_JAL: begin
        res.dest_write   = 1'b1;
        res.dest_value   = pc_seq;
        res.branch_taken = 1'b1;
        res.next_pc      = pc_rel;
      end
      CMD_JALR: begin
        res.dest_write   = 1'b1;
        res.dest_value   = pc_seq;
        res.branch_taken = 1'b1;
        res.next_pc      = {addr[XLEN-1:1], 1'b0};
      end
      CMD_LUI: begin
        res.dest_write = 1'b1;
        res.dest_value = imm64;
      end
      CMD_AUIPC: begin
        res.dest_write = 1'b1;
        res.dest_value = pc_rel;
      end
      default: begin
        // undefined codes: no write, no access, fall through to pc+4
        res.dest_write = 1'b0;
      end
    endcase
  end

endmodule

### rtl/rv64i_execute_unit.sv
// rv64i_execute_unit: top level, input register, rv64ex_alu and result register
// depends on rv64ex_pkg, rv64ex_channels and rv64ex_alu
// an accepted instruction is held in the input register, then its ALU result in the result register
// throughput: one instruction per cycle, limited only by downstream ready
// while a result waits, one more instruction is held in the input register
// reset: synchronous active-low rst_n clears both valid flags; payload is not reset
module rv64i_execute_unit (
  input  logic         clk,
  input  logic         rst_n,
  rv64ex_in_if.sink    in_ch,
  rv64ex_out_if.source out_ch
);
  import rv64ex_pkg::*;

  logic    s1_valid_r;
  logic    s1_valid_nxt;
  insn_t   s1_insn_r;
  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t out_res_r;
  result_t alu_res;
  logic    in_fire;
  logic    s1_fire;

  // stage one moves on when the result register is empty or being drained
  assign s1_fire = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_fire = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !s1_valid_r || s1_fire;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_insn_r.cmd            <= in_ch.cmd;
      s1_insn_r.first_operand  <= in_ch.first_operand;
      s1_insn_r.second_operand <= in_ch.second_operand;
      s1_insn_r.immediate      <= in_ch.immediate;
      s1_insn_r.current_pc     <= in_ch.current_pc;
      s1_insn_r.loaded_raw     <= in_ch.loaded_raw;
    end
    if (s1_fire) begin
      out_res_r <= alu_res;
    end
  end

  rv64ex_alu u_alu (
    .insn (s1_insn_r),
    .res  (alu_res)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.dest_value   = out_res_r.dest_value;
  assign out_ch.dest_write   = out_res_r.dest_write;
  assign out_ch.next_pc      = out_res_r.next_pc;
  assign out_ch.branch_taken = out_res_r.branch_taken;
  assign out_ch.mem_address  = out_res_r.mem_address;
  assign out_ch.mem_kind     = out_res_r.mem_kind;
  assign out_ch.mem_bytes    = out_res_r.mem_bytes;
  assign out_ch.store_value  = out_res_r.store_value;

endmodule

### dv/rv64i_execute_unit_tb.sv
// rv64i_execute_unit_tb: self-checking bench for the rv64i execute unit, directed table then random
// depends on rv64ex_pkg, the rv64ex channel interfaces and rv64i_execute_unit
module rv64i_execute_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rv64ex_pkg::*;

  localparam int CYCLE_LIMIT  = 600_000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN_TOP = '1;
  localparam logic [XLEN-1:0]  ONES  = '1;
  localparam logic [XLEN-1:0]  MIN_S = 64'h8000_0000_0000_0000;
  localparam logic [XLEN-1:0]  PC0   = 64'h0000_0000_8000_0000;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    result_t          res;
  } retire_t;

  typedef struct {
    insn_t   op;
    bit      typed;
    result_t golden;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n;

  rv64ex_in_if  in_ch ();
  rv64ex_out_if out_ch ();

  rv64i_execute_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  retire_t retire_q[$];
  vector_t vectors[$];
  int      mismatches  = 0;
  int      cycle_count = 0;
  int      hold_cycles = 0;
  bit      source_gaps = 1'b0;
  bit      sink_stalls = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [XLEN-1:0] sext_word(input logic [WORD_W-1:0] w);
    return {{(XLEN-WORD_W){w[WORD_W-1]}}, w};
  endfunction

  // architectural outcome of one decoded instruction
  function automatic result_t execute_insn(input insn_t op);
    result_t           r;
    logic [XLEN-1:0]   a, b, imm, pc, raw;
    logic [WORD_W-1:0] lo;
    logic [SH_W-1:0]   sh;
    logic [SHW_W-1:0]  shw;
    logic              cond;
    a    = op.first_operand;
    b    = op.second_operand;
    imm  = sext_word(op.immediate);
    pc   = op.current_pc;
    raw  = op.loaded_raw;
    lo   = a[WORD_W-1:0];
    r    = '0;
    cond = 1'b0;
    r.next_pc = pc + INSN_BYTES;
    // register shifts take the amount from rs2, immediate shifts from the immediate
    sh  = (op.cmd < CMD_ADDI) ? b[SH_W-1:0] : imm[SH_W-1:0];
    shw = sh[SHW_W-1:0];
    case (op.cmd)
      CMD_ADD:   r.dest_value = a + b;
      CMD_SUB:   r.dest_value = a - b;
      CMD_AND:   r.dest_value = a & b;
      CMD_OR:    r.dest_value = a | b;
      CMD_XOR:   r.dest_value = a ^ b;
      CMD_SLL,
      CMD_SLLI:  r.dest_value = a << sh;
      CMD_SRL,
      CMD_SRLI:  r.dest_value = a >> sh;
      CMD_SRA,
      CMD_SRAI:  r.dest_value = $signed(a) >>> sh;
      CMD_SLT:   r.dest_value = XLEN'($signed(a) < $signed(b));
      CMD_SLTU:  r.dest_value = XLEN'(a < b);
      CMD_ADDW:  r.dest_value = sext_word(lo + b[WORD_W-1:0]);
      CMD_SUBW:  r.dest_value = sext_word(lo - b[WORD_W-1:0]);
      CMD_SLLW,
      CMD_SLLIW: r.dest_value = sext_word(lo << shw);
      CMD_SRLW,
      CMD_SRLIW: r.dest_value = sext_word(lo >> shw);
      CMD_SRAW,
      CMD_SRAIW: r.dest_value = sext_word($signed(lo) >>> shw);
      CMD_ADDI:  r.dest_value = a + imm;
      CMD_ANDI:  r.dest_value = a & imm;
      CMD_ORI:   r.dest_value = a | imm;
      CMD_XORI:  r.dest_value = a ^ imm;
      CMD_SLTI:  r.dest_value = XLEN'($signed(a) < $signed(imm));
      CMD_SLTIU: r.dest_value = XLEN'(a < imm);
      CMD_ADDIW: r.dest_value = sext_word(lo + imm[WORD_W-1:0]);
      CMD_LB: begin
        r.mem_bytes = 4'd1; r.dest_value = {{56{raw[7]}}, raw[7:0]};
      end
      CMD_LBU: begin
        r.mem_bytes = 4'd1; r.dest_value = {56'b0, raw[7:0]};
      end
      CMD_LH: begin
        r.mem_bytes = 4'd2; r.dest_value = {{48{raw[15]}}, raw[15:0]};
      end
      CMD_LHU: begin
        r.mem_bytes = 4'd2; r.dest_value = {48'b0, raw[15:0]};
      end
      CMD_LW: begin
        r.mem_bytes = 4'd4; r.dest_value = sext_word(raw[31:0]);
      end
      CMD_LWU: begin
        r.mem_bytes = 4'd4; r.dest_value = {32'b0, raw[31:0]};
      end
      CMD_LD: begin
        r.mem_bytes = 4'd8; r.dest_value = raw;
      end
      CMD_SB: begin
        r.mem_bytes = 4'd1; r.store_value = {56'b0, b[7:0]};
      end
      CMD_SH: begin
        r.mem_bytes = 4'd2; r.store_value = {48'b0, b[15:0]};
      end
      CMD_SW: begin
        r.mem_bytes = 4'd4; r.store_value = {32'b0, b[31:0]};
      end
      CMD_SD: begin
        r.mem_bytes = 4'd8; r.store_value = b;
      end
      CMD_BEQ:   cond = (a == b);
      CMD_BNE:   cond = (a != b);
      CMD_BGE:   cond = !($signed(a) < $signed(b));
      CMD_BGEU:  cond = (a >= b);
      CMD_BLT:   cond = ($signed(a) < $signed(b));
      CMD_BLTU:  cond = (a < b);
      CMD_JAL: begin
        r.dest_value = pc + INSN_BYTES; r.branch_taken = 1'b1; r.next_pc = pc + imm;
      end
      CMD_JALR: begin
        r.dest_value   = pc + INSN_BYTES;
        r.branch_taken = 1'b1;
        r.next_pc      = (a + imm) & ~XLEN'(1);
      end
      CMD_LUI:   r.dest_value = imm;
      CMD_AUIPC: r.dest_value = pc + imm;
      default: ;
    endcase
    if (op.cmd <= CMD_LD || (op.cmd >= CMD_JAL && op.cmd <= CMD_AUIPC))
      r.dest_write = 1'b1;
    if (op.cmd >= CMD_LB && op.cmd <= CMD_LD)
      r.mem_kind = MEM_LOAD;
    else if (op.cmd >= CMD_SB && op.cmd <= CMD_SD)
      r.mem_kind = MEM_STORE;
    if (r.mem_kind != MEM_NONE)
      r.mem_address = a + imm;
    if (cond) begin
      r.branch_taken = 1'b1;
      r.next_pc      = pc + imm;
    end
    return r;
  endfunction

  function automatic insn_t mk_insn(input logic [CMD_W-1:0] c, input logic [XLEN-1:0] a,
                                    input logic [XLEN-1:0] b, input logic [IMM_W-1:0] imm,
                                    input logic [XLEN-1:0] pc, input logic [XLEN-1:0] raw);
    insn_t op;
    op.cmd            = c;
    op.first_operand  = a;
    op.second_operand = b;
    op.immediate      = imm;
    op.current_pc     = pc;
    op.loaded_raw     = raw;
    return op;
  endfunction

  function automatic result_t mk_res(input logic [XLEN-1:0] dv, input logic wr,
                                     input logic [XLEN-1:0] npc, input logic taken,
                                     input logic [XLEN-1:0] addr, input mem_kind_t kind,
                                     input logic [BYTES_W-1:0] nbytes,
                                     input logic [XLEN-1:0] sv);
    result_t r;
    r.dest_value   = dv;
    r.dest_write   = wr;
    r.next_pc      = npc;
    r.branch_taken = taken;
    r.mem_address  = addr;
    r.mem_kind     = kind;
    r.mem_bytes    = nbytes;
    r.store_value  = sv;
    return r;
  endfunction

  task automatic add_vector(input insn_t op, input bit typed, input result_t golden);
    vector_t v;
    v.op     = op;
    v.typed  = typed;
    v.golden = golden;
    vectors.push_back(v);
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [XLEN-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ONES;
      2:       return MIN_S;
      3:       return ~MIN_S;
      4:       return XLEN'($urandom_range(0, 64));
      5:       return {32'h0, 32'($urandom)};
      6:       return {32'hffff_ffff, 32'($urandom)};
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic logic [IMM_W-1:0] pick_immediate();
    logic [11:0] short_imm;
    short_imm = 12'($urandom);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      4:       return 32'($urandom_range(0, 63));
      5:       return {{20{short_imm[11]}}, short_imm};
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic insn_t random_insn();
    insn_t op;
    // a few unassigned codes among the real operations
    if ($urandom_range(0, 19) == 0)
      op.cmd = CMD_W'($urandom_range(CMD_AUIPC + 1, 2**CMD_W - 1));
    else
      op.cmd = CMD_W'($urandom_range(0, CMD_AUIPC));
    op.first_operand  = pick_operand();
    op.second_operand = ($urandom_range(0, 4) == 0) ? op.first_operand : pick_operand();
    op.immediate      = pick_immediate();
    op.current_pc     = pick_operand();
    op.loaded_raw     = {32'($urandom), 32'($urandom)};
    return op;
  endfunction

  // queue the outcome before offering, so it is in place by the time the transfer lands
  task automatic drive_insn(input insn_t op, input bit typed, input result_t golden);
    retire_t e;
    int      gap;
    e.cmd = op.cmd;
    e.res = typed ? golden : execute_insn(op);
    retire_q.push_back(e);
    gap = source_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.cmd            <= op.cmd;
    in_ch.first_operand  <= op.first_operand;
    in_ch.second_operand <= op.second_operand;
    in_ch.immediate      <= op.immediate;
    in_ch.current_pc     <= op.current_pc;
    in_ch.loaded_raw     <= op.loaded_raw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [CMD_W-1:0] c,
                             input logic [XLEN-1:0] want, input logic [XLEN-1:0] got);
    if (got !== want) begin
      $display("%0t: cmd %0d %s expected %h actual %h", $time, c, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    retire_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (retire_q.size() == 0) begin
        $display("%0t: result transfer with nothing outstanding, dest_value %h",
                 $time, out_ch.dest_value);
        mismatches++;
      end else begin
        e = retire_q.pop_front();
        check_field("dest_value",   e.cmd, e.res.dest_value,   out_ch.dest_value);
        check_field("dest_write",   e.cmd, XLEN'(e.res.dest_write),
                    XLEN'(out_ch.dest_write));
        check_field("next_pc",      e.cmd, e.res.next_pc,      out_ch.next_pc);
        check_field("branch_taken", e.cmd, XLEN'(e.res.branch_taken),
                    XLEN'(out_ch.branch_taken));
        check_field("mem_address",  e.cmd, e.res.mem_address,  out_ch.mem_address);
        check_field("mem_kind",     e.cmd, XLEN'(e.res.mem_kind), XLEN'(out_ch.mem_kind));
        check_field("mem_bytes",    e.cmd, XLEN'(e.res.mem_bytes), XLEN'(out_ch.mem_bytes));
        check_field("store_value",  e.cmd, e.res.store_value,  out_ch.store_value);
      end
    end
  end

  // result side: bursts of ready, random stalls, and the long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      int n;
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        n = sink_stalls ? pick_gap() : 0;
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("** rv64i_execute_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.cmd            <= '0;
    in_ch.first_operand  <= '0;
    in_ch.second_operand <= '0;
    in_ch.immediate      <= '0;
    in_ch.current_pc     <= '0;
    in_ch.loaded_raw     <= '0;

    // unassigned code with pc at the top of the address space, next pc wraps
    add_vector(mk_insn(CMD_UNKNOWN_TOP, ONES, ONES, '1, 64'hffff_ffff_ffff_fffc, ONES), 1'b1,
               mk_res('0, 1'b0, '0, 1'b0, '0, MEM_NONE, 4'd0, '0));
    add_vector(mk_insn(CMD_ADD, ONES, 64'd1, '0, PC0, '0), 1'b1,
               mk_res('0, 1'b1, PC0 + 4, 1'b0, '0, MEM_NONE, 4'd0, '0));
    add_vector(mk_insn(CMD_SUB, '0, 64'd1, '0, PC0, '0), 1'b1,
               mk_res(ONES, 1'b1, PC0 + 4, 1'b0, '0, MEM_NONE, 4'd0, '0));
    // only the low six bits of rs2 count
    add_vector(mk_insn(CMD_SLL, 64'd1, ONES, '0, PC0, '0), 1'b1,
               mk_res(MIN_S, 1'b1, PC0 + 4, 1'b0, '0, MEM_NONE, 4'd0, '0));
    add_vector(mk_insn(CMD_SRA, MIN_S, 64'd63, '0, PC0, '0), 1'b1,
               mk_res(ONES, 1'b1, PC0 + 4, 1'b0, '0, MEM_NONE, 4'd0, '0));
    add_vector(mk_insn(CMD_SLT, MIN_S, '0, '0, PC0, '0), 1'b1,
               mk_res(64'd1, 1'b1, PC0 + 4, 1'b0, '0, MEM_NONE, 4'd0, '0));
    add_vector(mk_insn(CMD_SLTU, MIN_S, '0, '0, PC0, '0), 1'b1,
               mk_res('0, 1'b1, PC0 + 4, 1'b0, '0, MEM_NONE, 4'd0, '0));
    // sllw keeps only 32 bits before sign extension
    add_vector(mk_insn(CMD_SLLW, 64'd1, 64'h3f, '0, PC0, '0), 1'b1,
               mk_res(64'hffff_ffff_8000_0000, 1'b1, PC0 + 4, 1'b0, '0, MEM_NONE, 4'd0, '0));
    add_vector(mk_insn(CMD_SRLW, 64'hffff_ffff_8000_0000, '0, '0, PC0, '0), 1'b1,
               mk_res(64'hffff_ffff_8000_0000, 1'b1, PC0 + 4, 1'b0, '0, MEM_NONE, 4'd0, '0));
    add_vector(mk_insn(CMD_SRAW, 64'h8000_0000, 64'd31, '0, PC0, '0), 1'b1,
               mk_res(ONES, 1'b1, PC0 + 4, 1'b0, '0, MEM_NONE, 4'd0, '0));
    add_vector(mk_insn(CMD_ADDIW, '0, '0, 32'hffff_ffff, PC0, '0), 1'b1,
               mk_res(ONES, 1'b1, PC0 + 4, 1'b0, '0, MEM_NONE, 4'd0, '0));
    add_vector(mk_insn(CMD_SLTIU, '0, '0, 32'hffff_ffff, PC0, '0), 1'b1,
               mk_res(64'd1, 1'b1, PC0 + 4, 1'b0, '0, MEM_NONE, 4'd0, '0));
    add_vector(mk_insn(CMD_SRAI, MIN_S, '0, 32'hffff_ffff, PC0, '0), 1'b1,
               mk_res(ONES, 1'b1, PC0 + 4, 1'b0, '0, MEM_NONE, 4'd0, '0));
    add_vector(mk_insn(CMD_SLLIW, ONES, '0, 32'd31, PC0, '0), 1'b1,
               mk_res(64'hffff_ffff_8000_0000, 1'b1, PC0 + 4, 1'b0, '0, MEM_NONE, 4'd0, '0));
    add_vector(mk_insn(CMD_LB, 64'h1000, '0, 32'hffff_ffff, PC0, 64'h1234_5678_9abc_de80),
               1'b1, mk_res(64'hffff_ffff_ffff_ff80, 1'b1, PC0 + 4, 1'b0, 64'hfff, MEM_LOAD,
                            4'd1, '0));
    add_vector(mk_insn(CMD_LBU, 64'h1000, '0, 32'hffff_ffff, PC0, 64'h1234_5678_9abc_de80),
               1'b1, mk_res(64'h80, 1'b1, PC0 + 4, 1'b0, 64'hfff, MEM_LOAD, 4'd1, '0));
    add_vector(mk_insn(CMD_LWU, ONES, ONES, 32'd8, PC0, 64'hdead_beef_8765_4321), 1'b0, '0);
    add_vector(mk_insn(CMD_LD, MIN_S, ONES, 32'h7fff_ffff, PC0, 64'hfedc_ba98_7654_3210),
               1'b0, '0);
    // effective address wraps to zero
    add_vector(mk_insn(CMD_SD, ONES, ONES, 32'd1, PC0, ONES), 1'b1,
               mk_res('0, 1'b0, PC0 + 4, 1'b0, '0, MEM_STORE, 4'd8, ONES));
    add_vector(mk_insn(CMD_SB, PC0, ONES, 32'h8000_0000, PC0, ONES), 1'b0, '0);
    add_vector(mk_insn(CMD_BLT, MIN_S, '0, 32'hffff_fff8, PC0, '0), 1'b1,
               mk_res('0, 1'b0, PC0 - 8, 1'b1, '0, MEM_NONE, 4'd0, '0));
    add_vector(mk_insn(CMD_BEQ, ONES, ONES, 32'h7fff_fffe, PC0, '0), 1'b0, '0);
    // jalr drops bit 0 of the target
    add_vector(mk_insn(CMD_JALR, 64'h1001, '0, '0, PC0, '0), 1'b1,
               mk_res(PC0 + 4, 1'b1, 64'h1000, 1'b1, '0, MEM_NONE, 4'd0, '0));
    add_vector(mk_insn(CMD_LUI, '0, '0, 32'h8000_0000, PC0, '0), 1'b1,
               mk_res(64'hffff_ffff_8000_0000, 1'b1, PC0 + 4, 1'b0, '0, MEM_NONE, 4'd0, '0));
    add_vector(mk_insn(CMD_AUIPC, '0, '0, 32'd8, 64'hffff_ffff_ffff_fffc, '0), 1'b0, '0);
    add_vector(mk_insn(CMD_JAL, '0, '0, 32'hffff_fffc, PC0, '0), 1'b0, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vectors[i])
      drive_insn(vectors[i].op, vectors[i].typed, vectors[i].golden);

    // phases: no idling, sender gaps, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      source_gaps = ph[0];
      sink_stalls = ph[1];
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
        if (sink_stalls && i == 100)
          hold_cycles = HOLD_CYCLES;
        drive_insn(random_insn(), 1'b0, '0);
      end
    end
    in_ch.valid <= 1'b0;

    while (retire_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("** rv64i_execute_unit: PASSED **");
    else
      $display("** rv64i_execute_unit: FAILED **");
    $finish;
  end

endmodule

### rv64i_execute_unit.f
rtl/rv64ex_pkg.sv
rtl/rv64ex_channels.sv
rtl/rv64ex_alu.sv
rtl/rv64i_execute_unit.sv
dv/rv64i_execute_unit_tb.sv
